// ===== sv/mm3_pkg.sv =====
// Shared constants, the queue entry type and the byte-mask helper for the MurmurHash3 x64-128 core.
package mm3_pkg;

    // Body mix multipliers and lane offsets.
    localparam logic [63:0] MIX_C1    = 64'h87c37b91114253d5;
    localparam logic [63:0] MIX_C2    = 64'h4cf5ad432745937f;
    localparam logic [63:0] LANE1_ADD = 64'h0000000052dce729;
    localparam logic [63:0] LANE2_ADD = 64'h0000000038495ab5;

    // Final avalanche multipliers.
    localparam logic [63:0] FIN_M1 = 64'hff51afd7ed558ccd;
    localparam logic [63:0] FIN_M2 = 64'hc4ceb9fe1a85ec53;

    localparam logic [4:0] BLOCK_BYTES = 5'd16;

    // Default depth of the queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;

    // One classified block, as it waits in the queue.
    typedef struct packed {
        logic [63:0] word0;  // bytes 0..7, already masked
        logic [63:0] word1;  // bytes 8..15, already masked
        logic [4:0]  count;  // bytes that count toward the message length
        logic        full;   // full block: run the lane mix
        logic        last;   // finalize after this block
    } blk_t;

    // Keeps the lowest n bytes of a 64-bit word.
    function automatic logic [63:0] byte_mask(input logic [2:0] n);
        logic [63:0] m;
        m = '0;
        for (int i = 0; i < 8; i++) begin
            m[i*8 +: 8] = (3'(i) < n) ? 8'hff : 8'h00;
        end
        return m;
    endfunction

endpackage

// ===== sv/mm3_front.sv =====
// Front end: accepts requests, masks short last blocks and queues them for the back end.
module mm3_front #(
    parameter int QUEUE_DEPTH = mm3_pkg::QUEUE_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  logic [63:0]   word_low,
    input  logic [63:0]   word_high,
    input  logic [4:0]    byte_count,
    input  logic          last_block,
    input  logic          q_pop,
    output logic          q_valid,
    output mm3_pkg::blk_t q_head
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    mm3_pkg::blk_t    q_mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] fill_reg, fill_next;

    mm3_pkg::blk_t entry;
    logic          push;
    logic          pop;
    logic          full_blk;

    // A block that is not the last, or that claims 16 or more bytes, is a full block.
    always_comb
    begin
        full_blk    = !last_block || byte_count[4];
        entry.full  = full_blk;
        entry.last  = last_block;
        entry.count = full_blk ? mm3_pkg::BLOCK_BYTES : byte_count;
        if (full_blk || byte_count[3])
        begin
            entry.word0 = word_low;
        end
        else
        begin
            entry.word0 = word_low & mm3_pkg::byte_mask(byte_count[2:0]);
        end
        if (full_blk)
        begin
            entry.word1 = word_high;
        end
        else if (byte_count[3])
        begin
            // Eight to fifteen bytes: the high word keeps count minus eight bytes.
            entry.word1 = word_high & mm3_pkg::byte_mask(byte_count[2:0]);
        end
        else
        begin
            entry.word1 = '0;
        end
    end

    assign in_stall = (fill_reg == CNT_W'(QUEUE_DEPTH));
    assign q_valid  = (fill_reg != '0);
    assign q_head   = q_mem_reg[rd_ptr_reg];
    assign push     = in_valid && !in_stall;
    assign pop      = q_pop && q_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= entry;
        end
    end

endmodule

// ===== sv/mm3_mul.sv =====
// Iterative 64x64 multiplier, low 64 bits of the product, one 32x32 partial product per cycle.
module mm3_mul (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] op_a,
    input  logic [63:0] op_b,
    output logic        done,
    output logic [63:0] product
);

    localparam logic [1:0] STEP_LL = 2'd0;
    localparam logic [1:0] STEP_HL = 2'd1;
    localparam logic [1:0] STEP_LH = 2'd2;

    logic [63:0] a_reg, b_reg;
    logic [63:0] acc_reg, acc_next;
    logic [1:0]  step_reg;
    logic        busy_reg;
    logic        done_reg;

    logic [31:0] x, y;
    logic [63:0] prod;

    always_comb
    begin
        case (step_reg)
            STEP_LL:
            begin
                x = a_reg[31:0];
                y = b_reg[31:0];
            end
            STEP_HL:
            begin
                x = a_reg[63:32];
                y = b_reg[31:0];
            end
            STEP_LH:
            begin
                x = a_reg[31:0];
                y = b_reg[63:32];
            end
            default:
            begin
                x = a_reg[31:0];
                y = b_reg[31:0];
            end
        endcase
        prod = {32'b0, x} * {32'b0, y};
        // Cross terms only reach the upper half of a 64-bit result.
        if (step_reg == STEP_LL)
        begin
            acc_next = prod;
        end
        else
        begin
            acc_next = acc_reg + {prod[31:0], 32'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= STEP_LL;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= STEP_LL;
            end
            else if (busy_reg)
            begin
                if (step_reg == STEP_LH)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    step_reg <= step_reg + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg <= op_a;
            b_reg <= op_b;
        end
        if (busy_reg)
        begin
            acc_reg <= acc_next;
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

// ===== sv/mm3_back.sv =====
// Back end: sequencer that runs the key scramble, lane mix and finalization on one multiplier.
module mm3_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          seed_we,
    input  logic [31:0]   seed_data,
    input  logic          q_valid,
    input  mm3_pkg::blk_t q_head,
    output logic          q_pop,
    output logic          out_valid,
    input  logic          out_stall,
    output logic [63:0]   hash_low,
    output logic [63:0]   hash_high
);

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_K2A   = 5'd1;
    localparam logic [4:0] S_K2B   = 5'd2;
    localparam logic [4:0] S_K1A   = 5'd3;
    localparam logic [4:0] S_K1B   = 5'd4;
    localparam logic [4:0] S_MIX1A = 5'd5;
    localparam logic [4:0] S_MIX1B = 5'd6;
    localparam logic [4:0] S_MIX2A = 5'd7;
    localparam logic [4:0] S_MIX2B = 5'd8;
    localparam logic [4:0] S_TAIL  = 5'd9;
    localparam logic [4:0] S_FIN0  = 5'd10;
    localparam logic [4:0] S_FIN1  = 5'd11;
    localparam logic [4:0] S_FM1A  = 5'd12;
    localparam logic [4:0] S_FM1B  = 5'd13;
    localparam logic [4:0] S_FM2A  = 5'd14;
    localparam logic [4:0] S_FM2B  = 5'd15;
    localparam logic [4:0] S_OUT0  = 5'd16;
    localparam logic [4:0] S_OUT1  = 5'd17;

    function automatic logic [63:0] rotl64(input logic [63:0] v, input int unsigned s);
        return (v << s) | (v >> (64 - s));
    endfunction

    function automatic logic [63:0] shx33(input logic [63:0] v);
        return v ^ (v >> 33);
    endfunction

    logic [4:0]    state_reg, state_next;
    logic [31:0]   seed_reg;
    logic [63:0]   lane1_reg, lane1_next;
    logic [63:0]   lane2_reg, lane2_next;
    logic [63:0]   len_reg, len_next;
    logic          in_msg_reg, in_msg_next;
    logic [63:0]   k2_reg, k2_next;
    mm3_pkg::blk_t blk_reg, blk_next;
    logic          pend_reg, pend_next;
    logic          out_valid_reg, out_valid_next;
    logic [63:0]   hash_low_reg, hash_low_next;
    logic [63:0]   hash_high_reg, hash_high_next;

    logic          mul_state;
    logic          mul_start;
    logic [63:0]   mul_a, mul_b;
    logic          mul_done;
    logic [63:0]   mul_p;

    mm3_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .done    (mul_done),
        .product (mul_p)
    );

    always_comb
    begin
        state_next     = state_reg;
        lane1_next     = lane1_reg;
        lane2_next     = lane2_reg;
        len_next       = len_reg;
        in_msg_next    = in_msg_reg;
        k2_next        = k2_reg;
        blk_next       = blk_reg;
        hash_low_next  = hash_low_reg;
        hash_high_next = hash_high_reg;
        out_valid_next = out_valid_reg;
        q_pop          = 1'b0;
        mul_a          = blk_reg.word1;
        mul_b          = mm3_pkg::MIX_C2;

        // Each multiply state issues once, then waits for the product.
        mul_state = state_reg inside {S_K2A, S_K2B, S_K1A, S_K1B, S_FM1A, S_FM1B, S_FM2A, S_FM2B};
        mul_start = mul_state && !pend_reg;
        if (mul_start)
        begin
            pend_next = 1'b1;
        end
        else if (mul_done)
        begin
            pend_next = 1'b0;
        end
        else
        begin
            pend_next = pend_reg;
        end

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                q_pop = q_valid;
                if (q_valid)
                begin
                    blk_next    = q_head;
                    in_msg_next = 1'b1;
                    if (in_msg_reg)
                    begin
                        len_next = len_reg + 64'(q_head.count);
                    end
                    else
                    begin
                        lane1_next = 64'(seed_reg);
                        lane2_next = 64'(seed_reg);
                        len_next   = 64'(q_head.count);
                    end
                    state_next = S_K2A;
                end
            end
            S_K2A:
            begin
                mul_a = blk_reg.word1;
                mul_b = mm3_pkg::MIX_C2;
                if (mul_done)
                begin
                    state_next = S_K2B;
                end
            end
            S_K2B:
            begin
                mul_a = rotl64(mul_p, 33);
                mul_b = mm3_pkg::MIX_C1;
                if (mul_done)
                begin
                    k2_next    = mul_p;
                    state_next = S_K1A;
                end
            end
            S_K1A:
            begin
                mul_a = blk_reg.word0;
                mul_b = mm3_pkg::MIX_C1;
                if (mul_done)
                begin
                    state_next = S_K1B;
                end
            end
            S_K1B:
            begin
                mul_a = rotl64(mul_p, 31);
                mul_b = mm3_pkg::MIX_C2;
                if (mul_done)
                begin
                    lane1_next = lane1_reg ^ mul_p;
                    state_next = blk_reg.full ? S_MIX1A : S_TAIL;
                end
            end
            S_MIX1A:
            begin
                lane1_next = rotl64(lane1_reg, 27) + lane2_reg;
                state_next = S_MIX1B;
            end
            S_MIX1B:
            begin
                lane1_next = (lane1_reg << 2) + lane1_reg + mm3_pkg::LANE1_ADD;
                state_next = S_MIX2A;
            end
            S_MIX2A:
            begin
                lane2_next = rotl64(lane2_reg ^ k2_reg, 31) + lane1_reg;
                state_next = S_MIX2B;
            end
            S_MIX2B:
            begin
                lane2_next = (lane2_reg << 2) + lane2_reg + mm3_pkg::LANE2_ADD;
                state_next = blk_reg.last ? S_FIN0 : S_IDLE;
            end
            S_TAIL:
            begin
                // A short block is always the last one.
                lane2_next = lane2_reg ^ k2_reg;
                state_next = S_FIN0;
            end
            S_FIN0:
            begin
                lane1_next = (lane1_reg ^ len_reg) + (lane2_reg ^ len_reg);
                lane2_next = lane2_reg ^ len_reg;
                state_next = S_FIN1;
            end
            S_FIN1:
            begin
                lane2_next = lane2_reg + lane1_reg;
                state_next = S_FM1A;
            end
            S_FM1A:
            begin
                mul_a = shx33(lane1_reg);
                mul_b = mm3_pkg::FIN_M1;
                if (mul_done)
                begin
                    state_next = S_FM1B;
                end
            end
            S_FM1B:
            begin
                mul_a = shx33(mul_p);
                mul_b = mm3_pkg::FIN_M2;
                if (mul_done)
                begin
                    lane1_next = shx33(mul_p);
                    state_next = S_FM2A;
                end
            end
            S_FM2A:
            begin
                mul_a = shx33(lane2_reg);
                mul_b = mm3_pkg::FIN_M1;
                if (mul_done)
                begin
                    state_next = S_FM2B;
                end
            end
            S_FM2B:
            begin
                mul_a = shx33(mul_p);
                mul_b = mm3_pkg::FIN_M2;
                if (mul_done)
                begin
                    lane2_next = shx33(mul_p);
                    state_next = S_OUT0;
                end
            end
            S_OUT0:
            begin
                lane1_next = lane1_reg + lane2_reg;
                state_next = S_OUT1;
            end
            S_OUT1:
            begin
                if (!out_valid_reg)
                begin
                    out_valid_next = 1'b1;
                    hash_low_next  = lane1_reg;
                    hash_high_next = lane2_reg + lane1_reg;
                    lane1_next     = '0;
                    lane2_next     = '0;
                    len_next       = '0;
                    in_msg_next    = 1'b0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            seed_reg      <= '0;
            lane1_reg     <= '0;
            lane2_reg     <= '0;
            len_reg       <= '0;
            in_msg_reg    <= 1'b0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            lane1_reg     <= lane1_next;
            lane2_reg     <= lane2_next;
            len_reg       <= len_next;
            in_msg_reg    <= in_msg_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
            if (seed_we)
            begin
                seed_reg <= seed_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        k2_reg        <= k2_next;
        blk_reg       <= blk_next;
        hash_low_reg  <= hash_low_next;
        hash_high_reg <= hash_high_next;
    end

    assign out_valid = out_valid_reg;
    assign hash_low  = hash_low_reg;
    assign hash_high = hash_high_reg;

endmodule

// ===== sv/murmur3_x64_128_hash.sv =====
// Top level of the MurmurHash3 x64-128 core: front end, block queue and back end sequencer.
// Each 16-byte block runs the key scramble and, when full, the lane mix; a last block adds
// the finalization before the hash is registered at the output.
// The back end shares a single 32x32 multiplier, used three times for each of the eight
// 64-bit multiplies. The input stalls while all queue entries wait for the back end.
// Reset clears the seed to zero, empties the queue, drops any pending hash and ends any message.
module murmur3_x64_128_hash #(
    parameter int QUEUE_DEPTH = mm3_pkg::QUEUE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    // Seed register write port.
    input  logic        seed_we,
    input  logic [31:0] seed_data,
    // Block requests.
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [63:0] word_low,
    input  logic [63:0] word_high,
    input  logic [4:0]  byte_count,
    input  logic        last_block,
    // Hash results.
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] hash_low,
    output logic [63:0] hash_high
);

    // Queue head and handshake between the two halves. The front end masks a short
    // last block and normalizes its byte count, so the back end only sees clean blocks.
    logic          q_valid;
    logic          q_pop;
    mm3_pkg::blk_t q_head;

    // The front end accepts a request whenever the queue has room, independent of
    // whether the back end is busy or a finished hash is still waiting to be taken.
    mm3_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .word_low   (word_low),
        .word_high  (word_high),
        .byte_count (byte_count),
        .last_block (last_block),
        .q_pop      (q_pop),
        .q_valid    (q_valid),
        .q_head     (q_head)
    );

    // The back end loads the seed into both lanes at the start of each message,
    // scrambles the two key words, mixes the lanes on full blocks, and on the last
    // block folds in the length and runs the avalanche on both halves. The result
    // sits in an output register until the receiver takes it.
    mm3_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .seed_we   (seed_we),
        .seed_data (seed_data),
        .q_valid   (q_valid),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .hash_low  (hash_low),
        .hash_high (hash_high)
    );

endmodule

// ===== sv/mm3_checker.sv =====
// Port-level checker for the MurmurHash3 x64-128 core, bound to the top level.
module mm3_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [63:0] hash_low,
    input logic [63:0] hash_high
);

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result withdrawn while stalled");

    // A stalled result keeps its value.
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(hash_low) && $stable(hash_high))
        else $error("result changed while stalled");

    // Right after reset the input is not stalled and no hash is pending.
    a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> !out_valid && !in_stall)
        else $error("block not empty after reset");

    // Each hash needs its own finalization, so a taken hash is never followed at once by another.
    a_no_repeat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall |=> !out_valid)
        else $error("result repeated or followed too closely");

endmodule

bind murmur3_x64_128_hash mm3_checker u_mm3_checker (.*);
